### rtl/core/delimiter_sniffer_macros.svh
// Assertion macros shared by the delimiter sniffer RTL.
`ifndef DELIMITER_SNIFFER_MACROS_SVH
`define DELIMITER_SNIFFER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("delimiter_sniffer: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define DS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("delimiter_sniffer: next-cycle check failed");

`endif

### rtl/core/dsniff_pkg.sv
// Shared types, character codes and helpers for the delimiter sniffer.
`timescale 1ns / 1ps

package dsniff_pkg;

    localparam int NUM_CAND      = 4;
    localparam int NUM_CHAR_CAND = 3;
    localparam int MIN_COLUMNS   = 2;
    localparam int RESULT_BITS   = 16;

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;

    // Candidate codes as reported on delimiter_index.
    typedef enum logic [1:0] {
        CAND_COMMA = 2'd0,
        CAND_TAB   = 2'd1,
        CAND_SEMI  = 2'd2,
        CAND_WORDS = 2'd3
    } cand_t;

    // Delimiter byte of each single-character candidate, by candidate code.
    localparam logic [NUM_CHAR_CAND-1:0][7:0] DELIM_CHARS = {CHAR_SEMI, CHAR_TAB, CHAR_COMMA};

    typedef struct packed {
        logic                   found;
        cand_t                  index;
        logic [RESULT_BITS-1:0] column_count;
    } pick_t;

    // Whitespace is tab through carriage return, plus space.
    function automatic logic is_ws(input logic [7:0] b);
        return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
    endfunction

endpackage

### rtl/core/dsniff_select.sv
// Winner selection over the first-line column counts of the four candidates.
`timescale 1ns / 1ps

module dsniff_select
    import dsniff_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic [NUM_CAND-1:0][COUNT_BITS-1:0] first_counts,
    input  logic [NUM_CAND-1:0]                 consistent,
    input  logic                                any_sampled,
    output pick_t                               pick
);

    localparam logic [COUNT_BITS-1:0] MIN_COLS = COUNT_BITS'(MIN_COLUMNS);

    logic                  best_hit;
    cand_t                 best_idx;
    logic [COUNT_BITS-1:0] best_cnt;
    logic [31:0]           best_wide;

    // Strict greater-than keeps ties on the lower candidate.
    always_comb
    begin
        best_hit = 1'b0;
        best_idx = CAND_COMMA;
        best_cnt = '0;
        for (int k = 0; k < NUM_CAND; k++)
        begin
            if (any_sampled && consistent[k] && (first_counts[k] >= MIN_COLS)
                && (first_counts[k] > best_cnt))
            begin
                best_hit = 1'b1;
                best_idx = cand_t'(2'(k));
                best_cnt = first_counts[k];
            end
        end
    end

    assign best_wide = 32'(best_cnt);

    always_comb
    begin
        pick.found        = best_hit;
        pick.index        = best_hit ? best_idx : CAND_COMMA;
        pick.column_count = '0;
        if (best_hit)
        begin
            pick.column_count = (best_wide > 32'h0000_FFFF) ? 16'hFFFF
                                                            : best_wide[RESULT_BITS-1:0];
        end
    end

endmodule

### rtl/core/delimiter_sniffer.sv
// Delimiter sniffer top level: byte intake, per-line column counting, result register.
//
// Usage: bytes of a text file enter on the byte channel (byte_valid/byte_ready,
// byte_value, last_byte), one per transaction, with last_byte set on the final
// byte. The block samples the first SAMPLE_LINES lines that hold non-whitespace,
// counts columns for comma, tab, semicolon and whitespace-separated words, and
// reports on the result channel (result_valid/result_ready) one transaction per
// file: found, delimiter_index and column_count.
// Throughput: one byte per cycle while no final byte is held back; each byte
// costs a single pass through the counter update logic between the input
// and state registers. A final byte in the input register loads the result register.
// Only a final byte needs the result register; other bytes keep flowing while a
// result waits. When the receiver stalls with a result pending, the next final
// byte holds in the input register and byte_ready drops until the result moves.
// Reset: all counts clear, every candidate is marked consistent, and both the
// input and result registers are empty. After each result the same sniffer state is
// restored, so the following byte starts a new file.
`timescale 1ns / 1ps
`include "delimiter_sniffer_macros.svh"

module delimiter_sniffer
    import dsniff_pkg::*;
#(
    parameter int SAMPLE_LINES = 5,
    parameter int COUNT_BITS   = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_ready,
    input  logic [7:0]             byte_value,
    input  logic                   last_byte,
    output logic                   result_valid,
    input  logic                   result_ready,
    output logic                   found,
    output logic [1:0]             delimiter_index,
    output logic [RESULT_BITS-1:0] column_count
);

    localparam int SAMP_BITS = $clog2(SAMPLE_LINES + 1);
    localparam logic [SAMP_BITS-1:0]  SAMP_LIMIT = SAMP_BITS'(SAMPLE_LINES);
    localparam logic [SAMP_BITS-1:0]  SAMP_ONE   = SAMP_BITS'(1);
    localparam logic [COUNT_BITS-1:0] CNT_ONE    = COUNT_BITS'(1);

    // Saturating increment: hold at the all-ones maximum.
    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] x);
        return (&x) ? x : x + CNT_ONE;
    endfunction

    // Input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg,  in_byte_next;
    logic       in_last_reg,  in_last_next;

    // Sniffer state
    logic [NUM_CAND-1:0][COUNT_BITS-1:0] first_reg, first_next;
    logic [NUM_CAND-1:0][COUNT_BITS-1:0] cur_reg,   cur_next;
    logic [NUM_CAND-1:0]                 cons_reg,  cons_next;
    logic                                inword_reg, inword_next;
    logic                                content_reg, content_next;
    logic [SAMP_BITS-1:0]                sampled_reg, sampled_next;

    // Result register
    logic                   out_valid_reg, out_valid_next;
    logic                   out_found_reg, out_found_next;
    logic [1:0]             out_index_reg, out_index_next;
    logic [RESULT_BITS-1:0] out_count_reg, out_count_next;

    // Per-byte update
    logic                                out_free;
    logic                                fire;
    logic                                active;
    logic                                is_lf;
    logic                                ws;
    logic [NUM_CAND-1:0][COUNT_BITS-1:0] cur_upd;
    logic [NUM_CAND-1:0][COUNT_BITS-1:0] line_cnt;
    logic [NUM_CAND-1:0][COUNT_BITS-1:0] col;
    logic [NUM_CAND-1:0][COUNT_BITS-1:0] first_new;
    logic [NUM_CAND-1:0]                 cons_new;
    logic [SAMP_BITS-1:0]                sampled_new;
    logic                                content_eff;
    logic                                close_line;
    logic                                take_sample;
    pick_t                               pick;

    // Handshake: a non-final byte always advances; a final byte needs the
    // result register to be empty or draining this cycle.
    assign out_free   = !out_valid_reg || result_ready;
    assign fire       = in_valid_reg && (!in_last_reg || out_free);
    assign byte_ready = !in_valid_reg || fire;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        in_last_next  = in_last_reg;
        if (byte_ready)
        begin
            in_valid_next = byte_valid;
            in_byte_next  = byte_value;
            in_last_next  = last_byte;
        end
    end

    // Count the byte into the current line: delimiter hits and word starts.
    assign active = sampled_reg < SAMP_LIMIT;
    assign is_lf  = in_byte_reg == CHAR_LF;
    assign ws     = is_ws(in_byte_reg);

    always_comb
    begin
        for (int k = 0; k < NUM_CHAR_CAND; k++)
        begin
            cur_upd[k] = (in_byte_reg == DELIM_CHARS[k]) ? sat_inc(cur_reg[k]) : cur_reg[k];
        end
        cur_upd[CAND_WORDS] = (!ws && !inword_reg) ? sat_inc(cur_reg[CAND_WORDS])
                                                   : cur_reg[CAND_WORDS];
    end

    // A newline closes the line without counting itself; a final byte is
    // counted first and then closes the line.
    always_comb
    begin
        if (active && !is_lf)
        begin
            line_cnt    = cur_upd;
            content_eff = content_reg || !ws;
        end
        else
        begin
            line_cnt    = cur_reg;
            content_eff = content_reg;
        end
    end

    assign close_line  = in_last_reg || (active && is_lf);
    assign take_sample = close_line && content_eff && active;

    // Fold the closed line into the first-line counts and consistency flags.
    always_comb
    begin
        for (int k = 0; k < NUM_CAND; k++)
        begin
            col[k] = (k < NUM_CHAR_CAND) ? sat_inc(line_cnt[k]) : line_cnt[k];
            first_new[k] = first_reg[k];
            cons_new[k]  = cons_reg[k];
            if (take_sample)
            begin
                if (sampled_reg == '0)
                begin
                    first_new[k] = col[k];
                end
                else if (col[k] != first_reg[k])
                begin
                    cons_new[k] = 1'b0;
                end
            end
        end
        sampled_new = take_sample ? sampled_reg + SAMP_ONE : sampled_reg;
    end

    dsniff_select #(
        .COUNT_BITS (COUNT_BITS)
    ) u_select (
        .first_counts (first_new),
        .consistent   (cons_new),
        .any_sampled  (sampled_new != '0),
        .pick         (pick)
    );

    // Next state: a final byte returns everything to its reset value.
    always_comb
    begin
        first_next   = first_reg;
        cur_next     = cur_reg;
        cons_next    = cons_reg;
        inword_next  = inword_reg;
        content_next = content_reg;
        sampled_next = sampled_reg;
        if (fire)
        begin
            if (in_last_reg)
            begin
                first_next   = '0;
                cur_next     = '0;
                cons_next    = '1;
                inword_next  = 1'b0;
                content_next = 1'b0;
                sampled_next = '0;
            end
            else if (close_line)
            begin
                first_next   = first_new;
                cons_next    = cons_new;
                sampled_next = sampled_new;
                cur_next     = '0;
                inword_next  = 1'b0;
                content_next = 1'b0;
            end
            else if (active)
            begin
                cur_next     = cur_upd;
                inword_next  = !ws;
                content_next = content_reg || !ws;
            end
        end
    end

    // Result register: load on a final byte, drop once taken.
    always_comb
    begin
        out_valid_next = out_valid_reg && !result_ready;
        out_found_next = out_found_reg;
        out_index_next = out_index_reg;
        out_count_next = out_count_reg;
        if (fire && in_last_reg)
        begin
            out_valid_next = 1'b1;
            out_found_next = pick.found;
            out_index_next = pick.index;
            out_count_next = pick.column_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            first_reg     <= '0;
            cur_reg       <= '0;
            cons_reg      <= '1;
            inword_reg    <= 1'b0;
            content_reg   <= 1'b0;
            sampled_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            first_reg     <= first_next;
            cur_reg       <= cur_next;
            cons_reg      <= cons_next;
            inword_reg    <= inword_next;
            content_reg   <= content_next;
            sampled_reg   <= sampled_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        in_byte_reg   <= in_byte_next;
        in_last_reg   <= in_last_next;
        out_found_reg <= out_found_next;
        out_index_reg <= out_index_next;
        out_count_reg <= out_count_next;
    end

    assign result_valid    = out_valid_reg;
    assign found           = out_found_reg;
    assign delimiter_index = out_index_reg;
    assign column_count    = out_count_reg;

    // Sample count never passes its limit.
    `DS_ASSERT_NOW(a_sampled_bound, clk, rst_n, 1'b1, sampled_reg <= SAMP_LIMIT)
    // A miss reports index and count as zero.
    `DS_ASSERT_NOW(a_miss_zero, clk, rst_n, result_valid && !found,
        (delimiter_index == CAND_COMMA) && (column_count == '0))
    // A hit always has at least two columns.
    `DS_ASSERT_NOW(a_hit_min_cols, clk, rst_n, result_valid && found,
        column_count >= RESULT_BITS'(MIN_COLUMNS))
    // A final byte leaves the sniffer state as after reset.
    `DS_ASSERT_NEXT(a_restart_clean, clk, rst_n, fire && in_last_reg,
        (sampled_reg == '0) && (&cons_reg) && !content_reg && !inword_reg && result_valid)

endmodule
